/* rtl/core/qyu_pkg.sv */
// Shared types, constants and functions of the quaternion yaw unwrap unit.
`timescale 1ns / 1ps
`default_nettype none
package qyu_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam int Q_W        = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 33;
    localparam int VEC_W      = 34;
    localparam int CORDIC_W   = 37;
    localparam int ANG_W      = 34;
    localparam int HEAD_W     = 16;
    localparam int TOTAL_W    = 32;
    localparam int SUM_W      = 34;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int MUL_LAST   = 4;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    typedef struct packed {
        logic                  load;
        logic                  mul;
        logic                  pre;
        logic                  iter;
        logic                  head;
        logic                  total;
        logic [ATAN_IDX_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic longint to_angle(longint v, int frac);
        int s;
        s = 30 - frac;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_q30(logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] r;
        unique case (idx)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/qyu_ifs.sv */
// Valid/ready channel interfaces for quaternion input and yaw result.
`timescale 1ns / 1ps
`default_nettype none
interface qyu_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qyu_pkg::Q_W-1:0]      q_w;
    logic signed [qyu_pkg::Q_W-1:0]      q_x;
    logic signed [qyu_pkg::Q_W-1:0]      q_y;
    logic signed [qyu_pkg::Q_W-1:0]      q_z;
    modport source (output valid, output q_w, output q_x, output q_y, output q_z,
                    input ready);
    modport sink   (input valid, input q_w, input q_x, input q_y, input q_z,
                    output ready);
endinterface

interface qyu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qyu_pkg::HEAD_W-1:0]   heading;
    logic signed [qyu_pkg::TOTAL_W-1:0]  yaw_total;
    logic                                total_saturated;
    modport source (output valid, output heading, output yaw_total,
                    output total_saturated, input ready);
    modport sink   (input valid, input heading, input yaw_total,
                    input total_saturated, output ready);
endinterface
`default_nettype wire

/* rtl/core/qyu_ctrl.sv */
// Controller state machine sequencing products, CORDIC and accumulation.
`timescale 1ns / 1ps
`default_nettype none
module qyu_ctrl #(
    parameter int CORDIC_STEPS = qyu_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output qyu_pkg::t_dp_cmd         o_cmd,
    input  qyu_pkg::t_dp_status      i_status
);

    localparam int NUM_ITER = (CORDIC_STEPS < qyu_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                  : qyu_pkg::ATAN_LEN;
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] ITER_LAST =
        qyu_pkg::ATAN_IDX_W'(NUM_ITER - 1);
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MUL_LAST =
        qyu_pkg::ATAN_IDX_W'(qyu_pkg::MUL_LAST);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_PRE   = 6'b000100,
        S_ITER  = 6'b001000,
        S_HEAD  = 6'b010000,
        S_TOTAL = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [qyu_pkg::ATAN_IDX_W-1:0]  r_step, n_step;
    logic                            w_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_load) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = S_PRE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_PRE: begin
                n_state = S_ITER;
                n_step  = '0;
            end
            S_ITER: begin
                if (r_step == ITER_LAST) begin
                    n_state = S_HEAD;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_HEAD: begin
                n_state = S_TOTAL;
            end
            S_TOTAL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = w_load;
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.pre   = (r_state == S_PRE);
        o_cmd.iter  = (r_state == S_ITER);
        o_cmd.head  = (r_state == S_HEAD);
        o_cmd.total = (r_state == S_TOTAL) && i_status.out_free;
        o_cmd.step  = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/qyu_dp.sv */
// Datapath: shared multiplier, iterative CORDIC, heading clamp and yaw total.
`timescale 1ns / 1ps
`default_nettype none
module qyu_dp #(
    parameter int ANGLE_FRAC_BITS = qyu_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [qyu_pkg::Q_W-1:0]       i_q_w,
    input  wire logic signed [qyu_pkg::Q_W-1:0]       i_q_x,
    input  wire logic signed [qyu_pkg::Q_W-1:0]       i_q_y,
    input  wire logic signed [qyu_pkg::Q_W-1:0]       i_q_z,
    input  qyu_pkg::t_dp_cmd                          i_cmd,
    output qyu_pkg::t_dp_status                       o_status,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [qyu_pkg::HEAD_W-1:0]         o_heading,
    output logic signed [qyu_pkg::TOTAL_W-1:0]        o_yaw_total,
    output logic                                      o_total_saturated
);

    localparam int     VW = qyu_pkg::VEC_W;
    localparam int     CW = qyu_pkg::CORDIC_W;
    localparam int     AW = qyu_pkg::ANG_W;
    localparam int     TW = qyu_pkg::TOTAL_W;
    localparam int     SW = qyu_pkg::SUM_W;
    localparam int     HW = qyu_pkg::HEAD_W;
    localparam int     RND_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam longint PI_Q      = qyu_pkg::to_angle(qyu_pkg::PI_Q30, ANGLE_FRAC_BITS);
    localparam longint TWO_PI_Q  = qyu_pkg::to_angle(qyu_pkg::TWO_PI_Q30, ANGLE_FRAC_BITS);
    localparam longint HEAD_MAX  = (longint'(1) <<< (HW - 1)) - 1;
    localparam longint HEAD_MIN  = -(longint'(1) <<< (HW - 1));
    localparam longint HI_LIM_L  = (PI_Q < HEAD_MAX) ? PI_Q : HEAD_MAX;
    localparam longint LO_LIM_L  = (-PI_Q > HEAD_MIN) ? -PI_Q : HEAD_MIN;

    localparam logic signed [AW-1:0] RND     = AW'(longint'(1) <<< (RND_SHIFT - 1));
    localparam logic signed [AW-1:0] HI_LIM  = AW'(HI_LIM_L);
    localparam logic signed [AW-1:0] LO_LIM  = AW'(LO_LIM_L);
    localparam logic signed [TW-1:0] PI_T    = TW'(PI_Q);
    localparam logic signed [TW-1:0] TWO_PI_T = TW'(TWO_PI_Q);
    localparam logic signed [AW-1:0] HALF_PI = AW'(qyu_pkg::HALF_PI_Q30);
    localparam logic signed [VW-1:0] ONE_Q28 = VW'(longint'(1) <<< 28);
    localparam logic signed [SW-1:0] TOT_MAX = SW'((longint'(1) <<< (TW - 1)) - 1);
    localparam logic signed [SW-1:0] TOT_MIN = SW'(-(longint'(1) <<< (TW - 1)));

    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MS_XY  = qyu_pkg::ATAN_IDX_W'(0);
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MS_WZ  = qyu_pkg::ATAN_IDX_W'(1);
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MS_YY  = qyu_pkg::ATAN_IDX_W'(2);
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MS_ZZ  = qyu_pkg::ATAN_IDX_W'(3);
    localparam logic [qyu_pkg::ATAN_IDX_W-1:0] MS_END = qyu_pkg::ATAN_IDX_W'(4);

    logic signed [qyu_pkg::Q_W-1:0]    r_w, r_x, r_y, r_z;
    logic signed [qyu_pkg::Q_W-1:0]    w_ma, w_mb;
    logic signed [qyu_pkg::PROD_W-1:0] r_prod;
    logic signed [qyu_pkg::ACC_W-1:0]  r_num, r_sq;
    logic signed [VW-1:0]              w_num, w_den;
    logic signed [CW-1:0]              r_cx, r_cy, n_cx, n_cy, w_xs, w_ys;
    logic signed [AW-1:0]              r_cz, n_cz, w_rnd, w_hclamp;
    logic                              r_zero;
    logic signed [HW-1:0]              r_head, r_prev;
    logic signed [TW-1:0]              r_total, w_diff, w_wrap;
    logic signed [SW-1:0]              w_sum;
    logic signed [TW-1:0]              w_sat_sum;
    logic                              w_sat;
    logic                              r_out_valid;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;

    always_comb begin
        unique case (i_cmd.step)
            MS_XY:   begin w_ma = r_x; w_mb = r_y; end
            MS_WZ:   begin w_ma = r_w; w_mb = r_z; end
            MS_YY:   begin w_ma = r_y; w_mb = r_y; end
            MS_ZZ:   begin w_ma = r_z; w_mb = r_z; end
            default: begin w_ma = '0;  w_mb = '0;  end
        endcase
    end

    assign w_num = {r_num, 1'b0};
    assign w_den = ONE_Q28 - {r_sq, 1'b0};

    assign w_xs = r_cx >>> i_cmd.step;
    assign w_ys = r_cy >>> i_cmd.step;

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        if (i_cmd.pre) begin
            if (w_den < 0) begin
                if (w_num >= 0) begin
                    n_cx = CW'(w_num);
                    n_cy = -CW'(w_den);
                    n_cz = HALF_PI;
                end else begin
                    n_cx = -CW'(w_num);
                    n_cy = CW'(w_den);
                    n_cz = -HALF_PI;
                end
            end else begin
                n_cx = CW'(w_den);
                n_cy = CW'(w_num);
                n_cz = '0;
            end
        end else if (i_cmd.iter) begin
            if (r_cy > 0) begin
                n_cx = r_cx + w_ys;
                n_cy = r_cy - w_xs;
                n_cz = r_cz + qyu_pkg::atan_q30(i_cmd.step);
            end else begin
                n_cx = r_cx - w_ys;
                n_cy = r_cy + w_xs;
                n_cz = r_cz - qyu_pkg::atan_q30(i_cmd.step);
            end
        end
    end

    always_comb begin
        w_rnd = (r_cz + RND) >>> RND_SHIFT;
        priority if (r_zero) begin
            w_hclamp = '0;
        end else if (w_rnd > HI_LIM) begin
            w_hclamp = HI_LIM;
        end else if (w_rnd < LO_LIM) begin
            w_hclamp = LO_LIM;
        end else begin
            w_hclamp = w_rnd;
        end
    end

    always_comb begin
        w_diff = TW'(r_head) - TW'(r_prev);
        priority if (w_diff > PI_T) begin
            w_wrap = w_diff - TWO_PI_T;
        end else if (w_diff < -PI_T) begin
            w_wrap = w_diff + TWO_PI_T;
        end else begin
            w_wrap = w_diff;
        end
        w_sum = SW'(r_total) + SW'(w_wrap);
        priority if (w_sum > TOT_MAX) begin
            w_sat_sum = TW'(TOT_MAX);
            w_sat     = 1'b1;
        end else if (w_sum < TOT_MIN) begin
            w_sat_sum = TW'(TOT_MIN);
            w_sat     = 1'b1;
        end else begin
            w_sat_sum = TW'(w_sum);
            w_sat     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= i_q_w;
            r_x <= i_q_x;
            r_y <= i_q_y;
            r_z <= i_q_z;
        end
        if (i_cmd.mul) begin
            r_prod <= w_ma * w_mb;
            unique case (i_cmd.step)
                MS_WZ:   r_num <= qyu_pkg::ACC_W'(r_prod);
                MS_YY:   r_num <= r_num + qyu_pkg::ACC_W'(r_prod);
                MS_ZZ:   r_sq  <= qyu_pkg::ACC_W'(r_prod);
                MS_END:  r_sq  <= r_sq + qyu_pkg::ACC_W'(r_prod);
                default: r_num <= r_num;
            endcase
        end
        if (i_cmd.pre) begin
            r_zero <= (w_num == 0) && (w_den == 0);
        end
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_cz <= n_cz;
        if (i_cmd.head) begin
            r_head <= HW'(w_hclamp);
        end
        if (i_cmd.total) begin
            o_heading         <= r_head;
            o_yaw_total       <= w_sat_sum;
            o_total_saturated <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.total) begin
                r_prev      <= r_head;
                r_total     <= w_sat_sum;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/quaternion_yaw_unwrap_accumulator_unit.sv */
// Top level of the quaternion yaw unwrap accumulator.
`timescale 1ns / 1ps
`default_nettype none
// Takes one quaternion (w, x, y, z, signed Q1.14) per transaction and returns
// its heading atan2(2(xy+wz), 1-2(y^2+z^2)) in radians with ANGLE_FRAC_BITS
// fraction bits, plus a running unwrapped yaw total that saturates at the
// signed 32-bit limits. Each quaternion passes in order through the products
// on the single shared 16x16 multiplier, a pre-rotation step, the CORDIC
// iterations, the heading clamp and the accumulation; the accumulation waits
// while the output register still holds an untaken result. One quaternion
// is in flight at a time; the result sits in an output register, so the next
// quaternion is accepted while a result waits. Previous heading and total
// reset to zero.
module quaternion_yaw_unwrap_accumulator_unit #(
    parameter int CORDIC_STEPS    = qyu_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = qyu_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qyu_in_if.sink      i_in,
    qyu_out_if.source   o_out
);

    qyu_pkg::t_dp_cmd    w_cmd;
    qyu_pkg::t_dp_status w_status;
    logic                w_in_ready;
    logic                w_out_valid;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    qyu_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    qyu_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_w             (i_in.q_w),
        .i_q_x             (i_in.q_x),
        .i_q_y             (i_in.q_y),
        .i_q_z             (i_in.q_z),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (w_out_valid),
        .i_out_ready       (o_out.ready),
        .o_heading         (o_out.heading),
        .o_yaw_total       (o_out.yaw_total),
        .o_total_saturated (o_out.total_saturated)
    );

endmodule
`default_nettype wire
